>>> rtl/cse_pkg.sv
// cse_pkg: widths, codes and the microcode table of the cosine similarity engine.
// Self-contained; used by rtl/cosine_similarity_engine.sv.
package cse_pkg;

  localparam int unsigned DOT_W    = 41;
  localparam int unsigned NORM_W   = 40;
  localparam int unsigned SIM_W    = 16;
  localparam int unsigned STATUS_W = 2;

  // shared multiplier: operands split into two halves
  localparam int unsigned MH_W  = 21;
  localparam int unsigned MOP_W = 2 * MH_W;
  localparam int unsigned MP_W  = 2 * MH_W;

  localparam int unsigned ACC_W  = 2 * NORM_W + 2;
  localparam int unsigned DEN_W  = 2 * NORM_W;
  localparam int unsigned Q_W    = 2 * (SIM_W - 1);
  localparam int unsigned ROOT_W = Q_W + 1;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned PC_W   = 5;

  localparam logic [DOT_W-1:0]  DOT_MAX  = {1'b0, {(DOT_W-1){1'b1}}};
  localparam logic [DOT_W-1:0]  DOT_MIN  = {1'b1, {(DOT_W-1){1'b0}}};
  localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};
  localparam logic [SIM_W-1:0]  MAG_ONE  = {1'b1, {(SIM_W-1){1'b0}}};
  localparam logic [SIM_W-1:0]  SIM_MAX  = {1'b0, {(SIM_W-1){1'b1}}};

  localparam logic [CNT_W-1:0] DIV_CNT_INIT  = CNT_W'(Q_W - 1);
  localparam logic [CNT_W-1:0] SQRT_CNT_INIT = CNT_W'(Q_W / 2 - 1);

  typedef logic [PC_W-1:0] upc_t;

  localparam upc_t S_IDLE      = 5'd0;
  localparam upc_t S_ZERO_CHK  = 5'd1;
  localparam upc_t S_NRM_P1    = 5'd2;
  localparam upc_t S_NRM_P2    = 5'd3;
  localparam upc_t S_NRM_P3    = 5'd4;
  localparam upc_t S_DOT_P0    = 5'd5;
  localparam upc_t S_DOT_P1    = 5'd6;
  localparam upc_t S_DOT_P2    = 5'd7;
  localparam upc_t S_DOT_P3    = 5'd8;
  localparam upc_t S_DOT_END   = 5'd9;
  localparam upc_t S_SAT_CHK   = 5'd10;
  localparam upc_t S_DIV_LOOP  = 5'd11;
  localparam upc_t S_SQRT_INIT = 5'd12;
  localparam upc_t S_SQRT_LOOP = 5'd13;
  localparam upc_t S_EMIT_ROOT = 5'd14;
  localparam upc_t S_EMIT_SAT  = 5'd15;
  localparam upc_t S_EMIT_ZERO = 5'd16;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_NORM = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    C_NONE,
    C_NOT_GO,
    C_ZERO_NORM,
    C_DEN_LE_ACC,
    C_CNT_NZ,
    C_OUT_BUSY
  } cond_e;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_MAC_LOAD,
    ALU_MAC_ADD,
    ALU_DIV_INIT,
    ALU_DIV_STEP,
    ALU_SQRT_INIT,
    ALU_SQRT_STEP
  } alu_e;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_ONE_HALF,
    SH_TWO_HALVES
  } shift_e;

  typedef enum logic {
    MS_NORMS,
    MS_DOT
  } mul_src_e;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_ROOT,
    OUT_SAT,
    OUT_ZERO
  } out_sel_e;

  typedef struct packed {
    cond_e    cond;
    upc_t     target;
    logic     ret;
    mul_src_e mul_src;
    logic     mul_xh;
    logic     mul_yh;
    alu_e     alu;
    shift_e   shift;
    logic     den_ld;
    out_sel_e out_sel;
  } uword_t;

  localparam uword_t UW_NOP = '{
    cond: C_NONE, target: S_IDLE, ret: 1'b0, mul_src: MS_NORMS, mul_xh: 1'b0,
    mul_yh: 1'b0, alu: ALU_NOP, shift: SH_NONE, den_ld: 1'b0, out_sel: OUT_NONE
  };

  // Program: norm product, dot squared, saturation check, long division,
  // integer square root, emit.
  function automatic uword_t ucode(input upc_t pc);
    uword_t w;
    w = UW_NOP;
    unique case (pc)
      S_IDLE: begin
        w.cond = C_NOT_GO;
        w.target = S_IDLE;
      end
      S_ZERO_CHK: begin
        w.cond = C_ZERO_NORM;
        w.target = S_EMIT_ZERO;
      end
      S_NRM_P1: begin
        w.mul_yh = 1'b1;
        w.alu = ALU_MAC_LOAD;
      end
      S_NRM_P2: begin
        w.mul_xh = 1'b1;
        w.alu = ALU_MAC_ADD;
        w.shift = SH_ONE_HALF;
      end
      S_NRM_P3: begin
        w.mul_xh = 1'b1;
        w.mul_yh = 1'b1;
        w.alu = ALU_MAC_ADD;
        w.shift = SH_ONE_HALF;
      end
      S_DOT_P0: begin
        w.mul_src = MS_DOT;
        w.alu = ALU_MAC_ADD;
        w.shift = SH_TWO_HALVES;
      end
      S_DOT_P1: begin
        w.mul_src = MS_DOT;
        w.mul_yh = 1'b1;
        w.den_ld = 1'b1;
        w.alu = ALU_MAC_LOAD;
      end
      S_DOT_P2: begin
        w.mul_src = MS_DOT;
        w.mul_xh = 1'b1;
        w.alu = ALU_MAC_ADD;
        w.shift = SH_ONE_HALF;
      end
      S_DOT_P3: begin
        w.mul_src = MS_DOT;
        w.mul_xh = 1'b1;
        w.mul_yh = 1'b1;
        w.alu = ALU_MAC_ADD;
        w.shift = SH_ONE_HALF;
      end
      S_DOT_END: begin
        w.alu = ALU_MAC_ADD;
        w.shift = SH_TWO_HALVES;
      end
      S_SAT_CHK: begin
        w.cond = C_DEN_LE_ACC;
        w.target = S_EMIT_SAT;
        w.alu = ALU_DIV_INIT;
      end
      S_DIV_LOOP: begin
        w.cond = C_CNT_NZ;
        w.target = S_DIV_LOOP;
        w.alu = ALU_DIV_STEP;
      end
      S_SQRT_INIT: begin
        w.alu = ALU_SQRT_INIT;
      end
      S_SQRT_LOOP: begin
        w.cond = C_CNT_NZ;
        w.target = S_SQRT_LOOP;
        w.alu = ALU_SQRT_STEP;
      end
      S_EMIT_ROOT: begin
        w.cond = C_OUT_BUSY;
        w.target = S_EMIT_ROOT;
        w.ret = 1'b1;
        w.out_sel = OUT_ROOT;
      end
      S_EMIT_SAT: begin
        w.cond = C_OUT_BUSY;
        w.target = S_EMIT_SAT;
        w.ret = 1'b1;
        w.out_sel = OUT_SAT;
      end
      S_EMIT_ZERO: begin
        w.cond = C_OUT_BUSY;
        w.target = S_EMIT_ZERO;
        w.ret = 1'b1;
        w.out_sel = OUT_ZERO;
      end
      default: begin
        w.ret = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/cosine_similarity_engine.sv
// Streaming cosine similarity: one element pair a cycle, one beat per final pair.
// The result of a final pair comes from the 30-step long division and 15-step square
// root loops of the microcode sequencer, which a zero norm or a saturating ratio skips.
// Ordinary pairs are taken one per cycle; input stalls from a final pair until its
// result is registered. Reset clears sums and sequencer at once.
// cosine_similarity_engine: top level, microcoded sequencer and datapath.
// Depends on rtl/cse_pkg.sv.
module cosine_similarity_engine import cse_pkg::*; #(
  parameter int ELEMENT_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [ELEMENT_BITS-1:0] element_a_i,
  input  logic signed [ELEMENT_BITS-1:0] element_b_i,
  input  logic                           last_pair_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SIM_W-1:0]        similarity_o,
  output logic [STATUS_W-1:0]            status_o
);

  localparam int PROD_W = 2 * ELEMENT_BITS;
  localparam int DSUM_W = ((PROD_W > DOT_W) ? PROD_W : DOT_W) + 1;
  localparam int NSUM_W = ((PROD_W > NORM_W) ? PROD_W : NORM_W) + 1;

  logic                     in_accept;
  logic signed [PROD_W-1:0] ab_w, aa_w, bb_w;
  logic signed [PROD_W-1:0] prod_ab_q;
  logic [PROD_W-1:0]        prod_aa_q, prod_bb_q;
  logic                     prod_vld_q, prod_last_q;
  logic                     go;

  logic [DOT_W-1:0]  dot_q, dot_d;
  logic [NORM_W-1:0] na_q, na_d, nb_q, nb_d;
  logic              ovf_q, ovf_d;
  logic [DSUM_W-1:0] dsum_w;
  logic [NSUM_W-1:0] nasum_w, nbsum_w;
  logic              dot_ovf, na_ovf, nb_ovf;

  upc_t   pc_q, pc_d;
  uword_t uw;
  logic   jump;
  logic   out_busy;
  logic   emit_fire;

  logic [DOT_W-1:0]  dmag_w;
  logic [MOP_W-1:0]  x_w, y_w;
  logic [MH_W-1:0]   x_half, y_half;
  logic [MP_W-1:0]   mul_w;
  logic [MP_W-1:0]   mp_q;
  logic [ACC_W-1:0]  mac_term;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [ACC_W-1:0]  den_ext, div_sh;
  logic              div_ge;
  logic [Q_W-1:0]    q_q, q_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [ROOT_W-1:0] sq_one, sq_trial, sq_rem;
  logic              sq_ge;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic [SIM_W-1:0]    mag_w, sim_w;
  status_e             status_w;
  logic                out_valid_q;
  logic [SIM_W-1:0]    sim_q;
  logic [STATUS_W-1:0] status_q;

  // input side: products registered, summed in the next cycle
  assign go         = prod_vld_q && prod_last_q;
  assign in_stall_o = (pc_q != S_IDLE) || go;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign ab_w = PROD_W'(element_a_i) * PROD_W'(element_b_i);
  assign aa_w = PROD_W'(element_a_i) * PROD_W'(element_a_i);
  assign bb_w = PROD_W'(element_b_i) * PROD_W'(element_b_i);

  assign dsum_w  = DSUM_W'($signed(dot_q)) + DSUM_W'(prod_ab_q);
  assign nasum_w = NSUM_W'(na_q) + NSUM_W'(prod_aa_q);
  assign nbsum_w = NSUM_W'(nb_q) + NSUM_W'(prod_bb_q);

  assign dot_ovf = !((&dsum_w[DSUM_W-1:DOT_W-1]) || !(|dsum_w[DSUM_W-1:DOT_W-1]));
  assign na_ovf  = |nasum_w[NSUM_W-1:NORM_W];
  assign nb_ovf  = |nbsum_w[NSUM_W-1:NORM_W];

  // sequencer
  assign uw       = ucode(pc_q);
  assign out_busy = out_valid_q && out_stall_i;

  always_comb begin
    unique case (uw.cond)
      C_NONE:       jump = 1'b0;
      C_NOT_GO:     jump = !go;
      C_ZERO_NORM:  jump = (na_q == '0) || (nb_q == '0);
      C_DEN_LE_ACC: jump = (den_ext <= acc_q);
      C_CNT_NZ:     jump = (cnt_q != '0);
      C_OUT_BUSY:   jump = out_busy;
      default:      jump = 1'b0;
    endcase
  end

  always_comb begin
    priority if (jump) begin
      pc_d = uw.target;
    end else if (uw.ret) begin
      pc_d = S_IDLE;
    end else begin
      pc_d = pc_q + upc_t'(1);
    end
  end

  assign emit_fire = (uw.out_sel != OUT_NONE) && !out_busy;

  always_comb begin
    dot_d = dot_q;
    na_d  = na_q;
    nb_d  = nb_q;
    ovf_d = ovf_q;
    priority if (emit_fire) begin
      dot_d = '0;
      na_d  = '0;
      nb_d  = '0;
      ovf_d = 1'b0;
    end else if (prod_vld_q) begin
      dot_d = dot_ovf ? (dsum_w[DSUM_W-1] ? DOT_MIN : DOT_MAX) : dsum_w[DOT_W-1:0];
      na_d  = na_ovf ? NORM_MAX : nasum_w[NORM_W-1:0];
      nb_d  = nb_ovf ? NORM_MAX : nbsum_w[NORM_W-1:0];
      ovf_d = ovf_q || dot_ovf || na_ovf || nb_ovf;
    end
  end

  // shared half-width multiplier
  assign dmag_w = dot_q[DOT_W-1] ? (~dot_q + DOT_W'(1)) : dot_q;
  assign x_w    = (uw.mul_src == MS_DOT) ? MOP_W'(dmag_w) : MOP_W'(na_q);
  assign y_w    = (uw.mul_src == MS_DOT) ? MOP_W'(dmag_w) : MOP_W'(nb_q);
  assign x_half = uw.mul_xh ? x_w[MOP_W-1:MH_W] : x_w[MH_W-1:0];
  assign y_half = uw.mul_yh ? y_w[MOP_W-1:MH_W] : y_w[MH_W-1:0];
  assign mul_w  = MP_W'(x_half) * MP_W'(y_half);

  always_comb begin
    unique case (uw.shift)
      SH_NONE:       mac_term = ACC_W'(mp_q);
      SH_ONE_HALF:   mac_term = ACC_W'(mp_q) << MH_W;
      SH_TWO_HALVES: mac_term = ACC_W'(mp_q) << (2 * MH_W);
      default:       mac_term = ACC_W'(mp_q);
    endcase
  end

  // restoring division of dot^2 * 2^30 by normA * normB; remainder kept in acc
  assign den_ext = ACC_W'(den_q);
  assign div_sh  = {acc_q[ACC_W-2:0], 1'b0};
  assign div_ge  = (div_sh >= den_ext);

  // integer square root of the quotient, two radicand bits a step
  assign sq_one   = ROOT_W'(1) << {cnt_q, 1'b0};
  assign sq_trial = root_q + sq_one;
  assign sq_rem   = ROOT_W'(q_q) - sq_trial;
  assign sq_ge    = (ROOT_W'(q_q) >= sq_trial);

  always_comb begin
    acc_d  = acc_q;
    den_d  = den_q;
    q_d    = q_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    if (uw.den_ld) begin
      den_d = acc_q[DEN_W-1:0];
    end
    unique case (uw.alu)
      ALU_NOP: begin
      end
      ALU_MAC_LOAD: begin
        acc_d = mac_term;
      end
      ALU_MAC_ADD: begin
        acc_d = acc_q + mac_term;
      end
      ALU_DIV_INIT: begin
        q_d   = '0;
        cnt_d = DIV_CNT_INIT;
      end
      ALU_DIV_STEP: begin
        acc_d = div_ge ? (div_sh - den_ext) : div_sh;
        q_d   = {q_q[Q_W-2:0], div_ge};
        cnt_d = cnt_q - CNT_W'(1);
      end
      ALU_SQRT_INIT: begin
        root_d = '0;
        cnt_d  = SQRT_CNT_INIT;
      end
      ALU_SQRT_STEP: begin
        q_d    = sq_ge ? sq_rem[Q_W-1:0] : q_q;
        root_d = sq_ge ? ((root_q >> 1) + sq_one) : (root_q >> 1);
        cnt_d  = cnt_q - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // result formatting
  always_comb begin
    unique case (uw.out_sel)
      OUT_ROOT: mag_w = root_q[SIM_W-1:0];
      OUT_SAT:  mag_w = MAG_ONE;
      default:  mag_w = '0;
    endcase
  end

  assign sim_w = dot_q[DOT_W-1] ? (~mag_w + SIM_W'(1))
                                : (mag_w[SIM_W-1] ? SIM_MAX : mag_w);
  assign status_w = (uw.out_sel == OUT_ZERO) ? ST_ZERO_NORM
                                             : (ovf_q ? ST_OVERFLOW : ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= S_IDLE;
      prod_vld_q  <= 1'b0;
      dot_q       <= '0;
      na_q        <= '0;
      nb_q        <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q       <= pc_d;
      prod_vld_q <= in_accept;
      dot_q      <= dot_d;
      na_q       <= na_d;
      nb_q       <= nb_d;
      ovf_q      <= ovf_d;
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      prod_ab_q   <= ab_w;
      prod_aa_q   <= aa_w;
      prod_bb_q   <= bb_w;
      prod_last_q <= last_pair_i;
    end
    mp_q   <= mul_w;
    acc_q  <= acc_d;
    den_q  <= den_d;
    q_q    <= q_d;
    root_q <= root_d;
    cnt_q  <= cnt_d;
    if (emit_fire) begin
      sim_q    <= sim_w;
      status_q <= status_w;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign similarity_o = sim_q;
  assign status_o     = status_q;

`ifndef NO_ASSERTIONS
  a_sums_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> (dot_q == '0) && (na_q == '0) && (nb_q == '0) && !ovf_q)
    else $error("sums not cleared after result beat");

  a_go_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |-> (pc_q == S_IDLE))
    else $error("final pair seen while sequencer busy");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == S_SQRT_INIT) |-> (acc_q < den_ext))
    else $error("division remainder not below divisor");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == S_EMIT_ROOT) |-> (root_q[ROOT_W-1:SIM_W-1] == '0))
    else $error("square root exceeds Q1.15 magnitude");
`endif

endmodule

>>> tb/cse_result_check.sv
`timescale 1ns / 100ps
// cse_result_check: watches both channels of cosine_similarity_engine, keeps its own
// running sums, works out each cosine and compares it with the result beats.
// Depends on rtl/cse_pkg.sv.
module cse_result_check import cse_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic signed [15:0] element_a_i,
  input  logic signed [15:0] element_b_i,
  input  logic              last_pair_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic signed [SIM_W-1:0] similarity_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic              drain_done_i,
  output int                open_results_o,
  output int                fail_count_o
);

  localparam longint DOT_TOP  = (longint'(1) <<< (DOT_W - 1)) - 1;
  localparam longint NORM_TOP = (longint'(1) <<< NORM_W) - 1;

  typedef struct packed {
    logic signed [SIM_W-1:0] sim;
    status_e                 status;
  } cosine_t;

  cosine_t cosines_due[$];
  logic signed [DOT_W-1:0] dot_q;
  logic [NORM_W-1:0] norm_a_q;
  logic [NORM_W-1:0] norm_b_q;
  logic sat_seen;
  int faults = 0;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    faults++;
  endtask

  // largest m with na*nb*m^2 <= dot^2 * 2^30, capped at one
  function automatic logic [SIM_W:0] cosine_magnitude(input logic [DOT_W-1:0] dmag,
                                                      input logic [NORM_W-1:0] na,
                                                      input logic [NORM_W-1:0] nb);
    logic [127:0] denom;
    logic [127:0] numer;
    logic [127:0] trial;
    logic [SIM_W:0] m;
    logic [SIM_W:0] c;
    denom = 128'(na) * 128'(nb);
    numer = (128'(dmag) * 128'(dmag)) << Q_W;
    m = '0;
    for (int i = SIM_W; i >= 0; i--) begin
      c = m | ((SIM_W + 1)'(1) << i);
      trial = denom * 128'(c) * 128'(c);
      if (trial <= numer) m = c;
    end
    return (m > 17'(MAG_ONE)) ? 17'(MAG_ONE) : m;
  endfunction

  function automatic cosine_t cosine_of_sums(input longint dot, input longint na,
                                             input longint nb, input logic clipped);
    cosine_t r;
    logic [SIM_W:0] m;
    r.sim = '0;
    r.status = ST_OK;
    if (na == 0 || nb == 0) begin
      r.status = ST_ZERO_NORM;
    end else begin
      m = cosine_magnitude(DOT_W'(dot < 0 ? -dot : dot), NORM_W'(na), NORM_W'(nb));
      if (dot < 0) begin
        r.sim = SIM_W'(17'd0 - m);
      end else begin
        r.sim = (m > 17'(SIM_MAX)) ? SIM_MAX : SIM_W'(m);
      end
      r.status = clipped ? ST_OVERFLOW : ST_OK;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    longint d;
    longint na;
    longint nb;
    cosine_t want;
    if (!rst_ni) begin
      cosines_due.delete();
      dot_q = '0;
      norm_a_q = '0;
      norm_b_q = '0;
      sat_seen = 1'b0;
      open_results_o <= 0;
      fail_count_o <= faults;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (cosines_due.size() == 0) begin
          report_mismatch($sformatf("result beat sim %0d status %0d with none due",
                                    similarity_i, status_i));
        end else begin
          want = cosines_due.pop_front();
          if (similarity_i !== want.sim)
            report_mismatch($sformatf("similarity %0d, expected %0d",
                                      similarity_i, want.sim));
          if (status_i !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_i, want.status));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        d  = longint'(dot_q) + longint'(element_a_i) * longint'(element_b_i);
        na = longint'(norm_a_q) + longint'(element_a_i) * longint'(element_a_i);
        nb = longint'(norm_b_q) + longint'(element_b_i) * longint'(element_b_i);
        if (d > DOT_TOP) begin
          d = DOT_TOP;
          sat_seen = 1'b1;
        end
        if (d < -DOT_TOP - 1) begin
          d = -DOT_TOP - 1;
          sat_seen = 1'b1;
        end
        if (na > NORM_TOP) begin
          na = NORM_TOP;
          sat_seen = 1'b1;
        end
        if (nb > NORM_TOP) begin
          nb = NORM_TOP;
          sat_seen = 1'b1;
        end
        if (last_pair_i) begin
          cosines_due.push_back(cosine_of_sums(d, na, nb, sat_seen));
          dot_q = '0;
          norm_a_q = '0;
          norm_b_q = '0;
          sat_seen = 1'b0;
        end else begin
          dot_q = DOT_W'(d);
          norm_a_q = NORM_W'(na);
          norm_b_q = NORM_W'(nb);
        end
      end
      if (drain_done_i && cosines_due.size() != 0) begin
        report_mismatch($sformatf("%0d results never arrived", cosines_due.size()));
        cosines_due.delete();
      end
      open_results_o <= cosines_due.size();
      fail_count_o <= faults;
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: drives element pairs into cosine_similarity_engine with bursty input and a
// stalling receiver; verdict from the counts of cse_result_check (tb/cse_result_check.sv).
module tb_top;
  import cse_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int RANDOM_ITEMS   = 400;

  typedef enum int {
    VK_RANDOM,
    VK_SAME,
    VK_OPPOSITE,
    VK_NEAR,
    VK_SMALL,
    VK_EXTREME,
    VK_ZERO_A
  } vec_kind_e;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] element_a_i = '0;
  logic signed [15:0] element_b_i = '0;
  logic last_pair_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [SIM_W-1:0] similarity_o;
  logic [STATUS_W-1:0] status_o;
  logic drain_done = 1'b0;
  int open_results;
  int fail_count;

  int items_sent = 0;
  int beats_left = 0;
  int stall_run = 0;
  int idle_cycles = 0;
  bit steady_tx = 1'b0;
  bit rx_busy = 1'b1;

  cosine_similarity_engine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .element_a_i (element_a_i),
    .element_b_i (element_b_i),
    .last_pair_i (last_pair_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .similarity_o(similarity_o),
    .status_o    (status_o)
  );

  cse_result_check u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .element_a_i   (element_a_i),
    .element_b_i   (element_b_i),
    .last_pair_i   (last_pair_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .similarity_i  (similarity_o),
    .status_i      (status_o),
    .drain_done_i  (drain_done),
    .open_results_o(open_results),
    .fail_count_o  (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      out_stall_i <= rx_busy && ($urandom_range(0, 2) == 0);
      stall_run <= $urandom_range(1, 12);
    end else begin
      stall_run <= stall_run - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no beat moved for %0d cycles", $time, idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                           input logic last);
    int gap;
    if (!steady_tx && beats_left <= 0) begin
      gap = $urandom_range(0, 6);
      beats_left = $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    beats_left--;
    in_valid_i <= 1'b1;
    element_a_i <= a;
    element_b_i <= b;
    last_pair_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic send_run(input logic signed [15:0] a, input logic signed [15:0] b,
                          input int count);
    for (int n = 1; n <= count; n++) send_pair(a, b, n == count);
  endtask

  task automatic wait_results_out();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (open_results != 0) @(posedge clk_i);
  endtask

  task automatic send_vector(input vec_kind_e kind, input int len);
    logic signed [15:0] a;
    logic signed [15:0] b;
    for (int n = 1; n <= len; n++) begin
      a = 16'($urandom);
      b = 16'($urandom);
      case (kind)
        VK_SAME:     b = a;
        VK_OPPOSITE: b = -a;
        VK_NEAR:     b = a + 16'($urandom_range(0, 64)) - 16'sd32;
        VK_SMALL: begin
          a = 16'($urandom_range(0, 8)) - 16'sd4;
          b = 16'($urandom_range(0, 8)) - 16'sd4;
        end
        VK_EXTREME: begin
          case ($urandom_range(0, 4))
            0: a = -16'sd32768;
            1: a = 16'sd32767;
            2: a = 16'sd0;
            3: a = 16'sd1;
            default: a = -16'sd1;
          endcase
          case ($urandom_range(0, 4))
            0: b = -16'sd32768;
            1: b = 16'sd32767;
            2: b = 16'sd0;
            3: b = 16'sd1;
            default: b = -16'sd1;
          endcase
        end
        VK_ZERO_A: a = '0;
        default: ;
      endcase
      send_pair(a, b, n == len);
    end
  endtask

  initial begin
    int target;
    int pick;
    int len;
    vec_kind_e kind;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single pairs: plus one, minus one, zero norms
    send_pair(16'sd32767, 16'sd32767, 1'b1);
    send_pair(-16'sd32768, -16'sd32768, 1'b1);
    send_pair(-16'sd32768, 16'sd32767, 1'b1);
    send_pair(16'sd32767, -16'sd32768, 1'b1);
    send_pair(16'sd1, -16'sd1, 1'b1);
    send_pair(-16'sd1, -16'sd1, 1'b1);
    send_pair(16'sd0, 16'sd5, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(-16'sd7, 16'sd0, 1'b1);
    // orthogonal, short mixed vectors, zero first vector
    send_pair(16'sd5, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd7, 1'b1);
    send_pair(16'sd1, 16'sd1, 1'b0);
    send_pair(-16'sd1, 16'sd2, 1'b0);
    send_pair(16'sd100, -16'sd300, 1'b1);
    send_pair(16'sd0, 16'sd3, 1'b0);
    send_pair(16'sd0, -16'sd4, 1'b1);
    send_pair(16'sd3, -16'sd4, 1'b0);
    send_pair(-16'sd32768, 16'sd32767, 1'b0);
    send_pair(16'sd12345, -16'sd23456, 1'b1);
    wait_results_out();

    // shortest vector that pushes every sum past its limit
    send_run(-16'sd32768, -16'sd32768, 1024);
    wait_results_out();

    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      steady_tx = ($urandom_range(0, 4) == 0);
      rx_busy = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 30) kind = VK_RANDOM;
      else if (pick < 42) kind = VK_SAME;
      else if (pick < 54) kind = VK_OPPOSITE;
      else if (pick < 70) kind = VK_NEAR;
      else if (pick < 80) kind = VK_SMALL;
      else if (pick < 94) kind = VK_EXTREME;
      else kind = VK_ZERO_A;
      pick = $urandom_range(0, 99);
      if (pick < 70) len = $urandom_range(1, 8);
      else if (pick < 96) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 300);
      send_vector(kind, len);
      if ($urandom_range(0, 9) == 0) wait_results_out();
    end

    wait_results_out();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> cosine_similarity_engine.f
rtl/cse_pkg.sv
rtl/cosine_similarity_engine.sv
tb/cse_result_check.sv
tb/tb_top.sv
